FILE: design/rsd_pkg.sv
// Shared constants, types and register codes for the radix digit converter.
// No dependencies; every other file refers to this package by scoped names.
package rsd_pkg;

    localparam int MAX_SYMBOLS  = 16;
    localparam int NUMBER_BITS  = 32;
    localparam int ALPHA_SYMS   = 16;
    localparam int SYM_W        = 8;
    localparam int CFG_W        = 64;
    localparam int CFG_IDX_W    = 8;
    localparam int MIN_RADIX    = 2;

    localparam logic [CFG_IDX_W-1:0] REG_ALPHA_LOW  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA_HIGH = CFG_IDX_W'(1);

    localparam logic [SYM_W-1:0] SYM_PLUS  = 8'h2B;
    localparam logic [SYM_W-1:0] SYM_MINUS = 8'h2D;

    localparam int RADIX_W      = $clog2(MAX_SYMBOLS + 1);
    localparam int DIGIT_W      = $clog2(MAX_SYMBOLS);
    localparam int DIGIT_DEPTH  = NUMBER_BITS;
    localparam int DIG_IDX_W    = $clog2(DIGIT_DEPTH);
    localparam int DIG_CNT_W    = $clog2(DIGIT_DEPTH + 1);
    localparam int BITS_PER_CYC = 8;
    localparam int BIT_CNT_W    = $clog2(NUMBER_BITS + BITS_PER_CYC);

    localparam int QUEUE_DEPTH  = 2;
    localparam int Q_PTR_W      = $clog2(QUEUE_DEPTH);
    localparam int Q_CNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef logic [ALPHA_SYMS-1:0][SYM_W-1:0] t_alpha;

    typedef struct packed {
        logic [NUMBER_BITS-1:0] mag;
        logic                   neg;
        logic [RADIX_W-1:0]     radix;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

FILE: design/rsd_front.sv
// Front end: alphabet registers, input capture, alphabet check and job build.
// Depends on rsd_pkg; pushes jobs into rsd_queue.
module rsd_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic signed [31:0]               i_number,
    output logic                             o_busy,
    input  logic                             i_cfg_we,
    input  logic [rsd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [rsd_pkg::CFG_W-1:0]        i_cfg_data,
    output rsd_pkg::t_alpha                  o_alpha,
    output logic                             o_push,
    output rsd_pkg::t_job                    o_job,
    input  rsd_pkg::t_q_stat                 i_q_stat
);

    logic [rsd_pkg::CFG_W-1:0]       r_alpha_low;
    logic [rsd_pkg::CFG_W-1:0]       r_alpha_high;
    logic                            r_fv;
    logic [rsd_pkg::NUMBER_BITS-1:0] r_value;

    rsd_pkg::t_alpha                 alpha;
    logic [rsd_pkg::ALPHA_SYMS-1:0]  in_set;
    logic [rsd_pkg::RADIX_W-1:0]     count;
    logic                            bad;
    logic                            radix_ok;
    logic                            accept;
    logic                            neg;

    assign alpha = {r_alpha_high, r_alpha_low};

    // Alphabet length and validity: prefix of nonzero symbols, no sign chars, no repeats.
    always_comb begin
        logic prefix;
        prefix = 1'b1;
        count  = '0;
        bad    = 1'b0;
        for (int i = 0; i < rsd_pkg::ALPHA_SYMS; i++) begin
            if (i < rsd_pkg::MAX_SYMBOLS) begin
                prefix = prefix & (alpha[i] != '0);
            end else begin
                prefix = 1'b0;
            end
            in_set[i] = prefix;
            count     = count + rsd_pkg::RADIX_W'(prefix);
        end
        for (int i = 0; i < rsd_pkg::ALPHA_SYMS; i++) begin
            if (in_set[i] && (alpha[i] == rsd_pkg::SYM_PLUS || alpha[i] == rsd_pkg::SYM_MINUS)) begin
                bad = 1'b1;
            end
            for (int j = i + 1; j < rsd_pkg::ALPHA_SYMS; j++) begin
                if (in_set[j] && alpha[i] == alpha[j]) begin
                    bad = 1'b1;
                end
            end
        end
    end

    assign radix_ok = !bad && (count >= rsd_pkg::RADIX_W'(rsd_pkg::MIN_RADIX));
    assign o_busy   = r_fv && radix_ok && i_q_stat.full;
    assign accept   = i_start && !o_busy;
    assign o_push   = r_fv && radix_ok && !i_q_stat.full;

    assign neg       = r_value[rsd_pkg::NUMBER_BITS-1];
    assign o_job.neg = neg;
    assign o_job.mag = neg ? (~r_value + 1'b1) : r_value;
    assign o_job.radix = count;
    assign o_alpha   = alpha;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha_low  <= '0;
            r_alpha_high <= '0;
            r_fv         <= 1'b0;
        end else begin
            if (i_cfg_we && i_cfg_index == rsd_pkg::REG_ALPHA_LOW) begin
                r_alpha_low <= i_cfg_data;
            end
            if (i_cfg_we && i_cfg_index == rsd_pkg::REG_ALPHA_HIGH) begin
                r_alpha_high <= i_cfg_data;
            end
            // an item with a bad alphabet is simply dropped
            r_fv <= accept || o_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_value <= i_number[rsd_pkg::NUMBER_BITS-1:0];
        end
    end

endmodule

FILE: design/rsd_queue.sv
// Short job queue between front end and digit engine.
// Depends on rsd_pkg.
module rsd_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  rsd_pkg::t_job    i_job,
    input  logic             i_pop,
    output rsd_pkg::t_job    o_job,
    output rsd_pkg::t_q_stat o_stat
);

    rsd_pkg::t_job                r_mem [rsd_pkg::QUEUE_DEPTH];
    logic [rsd_pkg::Q_PTR_W-1:0]  r_wp;
    logic [rsd_pkg::Q_PTR_W-1:0]  r_rp;
    logic [rsd_pkg::Q_CNT_W-1:0]  r_cnt;

    localparam logic [rsd_pkg::Q_PTR_W-1:0] PTR_LAST =
        rsd_pkg::Q_PTR_W'(rsd_pkg::QUEUE_DEPTH - 1);

    assign o_job        = r_mem[r_rp];
    assign o_stat.full  = (r_cnt == rsd_pkg::Q_CNT_W'(rsd_pkg::QUEUE_DEPTH));
    assign o_stat.empty = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PTR_LAST) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == PTR_LAST) ? '0 : r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

endmodule

FILE: design/rsd_back.sv
// Digit engine: iterative divide by the radix, digit buffer, symbol emission.
// Depends on rsd_pkg; pops jobs from rsd_queue.
module rsd_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  rsd_pkg::t_alpha              i_alpha,
    input  rsd_pkg::t_job                i_job,
    input  rsd_pkg::t_q_stat             i_q_stat,
    output logic                         o_pop,
    output logic                         o_strobe,
    output logic [rsd_pkg::SYM_W-1:0]    o_symbol,
    output logic                         o_last
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_SIGN = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0]                        r_state;
    logic [rsd_pkg::NUMBER_BITS-1:0]   r_quo;
    logic [rsd_pkg::RADIX_W-1:0]       r_rem;
    logic [rsd_pkg::BIT_CNT_W-1:0]     r_bits;
    logic [rsd_pkg::RADIX_W-1:0]       r_radix;
    logic                              r_neg;
    logic [rsd_pkg::DIG_CNT_W-1:0]     r_nd;
    logic [rsd_pkg::DIGIT_W-1:0]       r_dig [rsd_pkg::DIGIT_DEPTH];
    logic                              r_strobe;
    logic [rsd_pkg::SYM_W-1:0]         r_symbol;
    logic                              r_last;

    logic [rsd_pkg::NUMBER_BITS-1:0]   quo;
    logic [rsd_pkg::RADIX_W-1:0]       rem;
    logic [rsd_pkg::BIT_CNT_W-1:0]     bits_next;
    logic                              digit_done;
    logic [rsd_pkg::DIG_CNT_W-1:0]     nd_m1;

    // Restoring division, BITS_PER_CYC quotient bits per cycle. Dividend bits
    // shift out of the top of r_quo while quotient bits fill in at the bottom.
    always_comb begin
        logic [rsd_pkg::RADIX_W:0] sh;
        quo = r_quo;
        rem = r_rem;
        sh  = '0;
        for (int k = 0; k < rsd_pkg::BITS_PER_CYC; k++) begin
            if (int'(r_bits) + k < rsd_pkg::NUMBER_BITS) begin
                sh  = {rem, quo[rsd_pkg::NUMBER_BITS-1]};
                quo = {quo[rsd_pkg::NUMBER_BITS-2:0], 1'b0};
                if (sh >= {1'b0, r_radix}) begin
                    sh     = sh - {1'b0, r_radix};
                    quo[0] = 1'b1;
                end
                rem = sh[rsd_pkg::RADIX_W-1:0];
            end
        end
    end

    assign bits_next  = r_bits + rsd_pkg::BIT_CNT_W'(rsd_pkg::BITS_PER_CYC);
    assign digit_done = (int'(bits_next) >= rsd_pkg::NUMBER_BITS);
    assign nd_m1      = r_nd - 1'b1;
    assign o_pop      = (r_state == ST_IDLE) && !i_q_stat.empty;

    assign o_strobe = r_strobe;
    assign o_symbol = r_symbol;
    assign o_last   = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (o_pop) begin
                        r_state <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (digit_done && quo == '0) begin
                        r_state <= r_neg ? ST_SIGN : ST_EMIT;
                    end
                end
                ST_SIGN: begin
                    r_strobe <= 1'b1;
                    r_state  <= ST_EMIT;
                end
                ST_EMIT: begin
                    r_strobe <= 1'b1;
                    if (r_nd == rsd_pkg::DIG_CNT_W'(1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_quo   <= i_job.mag;
                r_neg   <= i_job.neg;
                r_radix <= i_job.radix;
                r_rem   <= '0;
                r_bits  <= '0;
                r_nd    <= '0;
            end
            ST_DIV: begin
                r_quo <= quo;
                if (digit_done) begin
                    r_dig[r_nd[rsd_pkg::DIG_IDX_W-1:0]] <= rem[rsd_pkg::DIGIT_W-1:0];
                    r_nd   <= r_nd + 1'b1;
                    r_rem  <= '0;
                    r_bits <= '0;
                end else begin
                    r_rem  <= rem;
                    r_bits <= bits_next;
                end
            end
            ST_SIGN: begin
                r_symbol <= rsd_pkg::SYM_MINUS;
                r_last   <= 1'b0;
            end
            ST_EMIT: begin
                r_symbol <= i_alpha[r_dig[nd_m1[rsd_pkg::DIG_IDX_W-1:0]]];
                r_last   <= (r_nd == rsd_pkg::DIG_CNT_W'(1));
                r_nd     <= nd_m1;
            end
            default: begin
                r_nd <= r_nd;
            end
        endcase
    end

endmodule

FILE: design/signed_int_to_radix_digits.sv
// Signed 32-bit integer to text in a radix given by a configured symbol alphabet.
// Depends on rsd_pkg, rsd_front, rsd_queue and rsd_back.
//
// Write the alphabet (registers 0 and 1, up to 16 byte symbols, ended by a zero
// byte) while the block is idle, then pulse i_start with a number whenever
// o_busy is low. Each output character appears on o_symbol for one cycle with
// o_strobe high; the receiver cannot stall, so it must take every beat. A
// negative number gives a leading '-', then the magnitude's digits most
// significant first; o_last marks the final one. With an invalid alphabet
// (fewer than two symbols, a '+' or '-', or a repeated symbol) a number gives
// no output. A number is captured in a register, the alphabet is checked as its
// job is pushed into the queue, and the digit engine loads it from there; the
// divider then finds each digit at 8 quotient bits a cycle over 32 bits, and
// the output gives one character per cycle. A two-entry job queue lets the next
// numbers be taken while the divider works.
module signed_int_to_radix_digits (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    output logic                             o_busy,
    input  logic signed [31:0]               i_number,
    input  logic                             i_cfg_we,
    input  logic [rsd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [rsd_pkg::CFG_W-1:0]        i_cfg_data,
    output logic                             o_strobe,
    output logic [7:0]                       o_symbol,
    output logic                             o_last
);

    rsd_pkg::t_alpha  alpha;
    logic             push;
    logic             pop;
    rsd_pkg::t_job    job_in;
    rsd_pkg::t_job    job_out;
    rsd_pkg::t_q_stat q_stat;

    rsd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .i_number    (i_number),
        .o_busy      (o_busy),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_alpha     (alpha),
        .o_push      (push),
        .o_job       (job_in),
        .i_q_stat    (q_stat)
    );

    rsd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job_in),
        .i_pop   (pop),
        .o_job   (job_out),
        .o_stat  (q_stat)
    );

    rsd_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_alpha  (alpha),
        .i_job    (job_out),
        .i_q_stat (q_stat),
        .o_pop    (pop),
        .o_strobe (o_strobe),
        .o_symbol (o_symbol),
        .o_last   (o_last)
    );

endmodule
